[rtl/core/lrra_pkg.sv]
// shared types and codes for the locked region ring allocator
`timescale 1ns / 1ps
`default_nettype none
package lrra_pkg;
   localparam int unsigned FW = 21;
   localparam int unsigned WW = 23;
   localparam logic [FW-1:0] MAX_SPACE = 21'd1048576;

   typedef logic [FW-1:0] field_type;
   typedef logic [WW-1:0] wide_type;
   typedef logic [2:0]    mode_type;
   typedef logic [3:0]    status_type;

   localparam mode_type MODE_APPEND      = 3'd0;
   localparam mode_type MODE_CONSUME     = 3'd1;
   localparam mode_type MODE_LOCK        = 3'd2;
   localparam mode_type MODE_UNLOCK      = 3'd3;
   localparam mode_type MODE_APPEND_LOCK = 3'd4;
   localparam mode_type MODE_ABORT       = 3'd5;
   localparam mode_type MODE_CLEAR_ABORT = 3'd6;

   localparam status_type ST_OK         = 4'd0;
   localparam status_type ST_BLOCKED    = 4'd1;
   localparam status_type ST_ABORTED    = 4'd2;
   localparam status_type ST_TOO_LARGE  = 4'd3;
   localparam status_type ST_NO_ROOM    = 4'd4;
   localparam status_type ST_BAD_REGION = 4'd5;
   localparam status_type ST_NOT_CONTIG = 4'd6;
   localparam status_type ST_NOT_FOUND  = 4'd7;
   localparam status_type ST_TABLE_FULL = 4'd8;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } cmd_type;
endpackage
`default_nettype wire

[rtl/core/lrra_ctrl.sv]
// controller: sequences load, lock table scan and finish of one beat
`timescale 1ns / 1ps
`default_nettype none
module lrra_ctrl #(
   parameter int unsigned MAX_LOCKS = 16,
   parameter int unsigned IW = 4
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   output logic                busy,
   output lrra_pkg::cmd_type   cmd,
   output logic [IW-1:0]       scan_idx
);
   import lrra_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_FIN  = 3'b100
   } state_type;

   state_type     state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic          last;

   assign last = (cnt_ff == IW'(MAX_LOCKS - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (start) state_in = S_SCAN;
         end
         S_SCAN: begin
            cnt_in = cnt_ff + IW'(1);
            if (last) state_in = S_FIN;
         end
         S_FIN: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign cmd.load   = (state_ff == S_IDLE) && start;
   assign cmd.scan   = (state_ff == S_SCAN);
   assign cmd.finish = (state_ff == S_FIN);
   assign scan_idx   = cnt_ff;

   a_fin_once: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !cmd.finish) else $error("finish held");
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> busy) else $error("no busy after load");
   a_fin_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> $past(cmd.scan)) else $error("finish without scan");
endmodule
`default_nettype wire

[rtl/core/lrra_dp.sv]
// datapath: buffer state, lock table, scan results and response registers
`timescale 1ns / 1ps
`default_nettype none
module lrra_dp #(
   parameter int unsigned MAX_LOCKS = 16,
   parameter int unsigned IW = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lrra_pkg::cmd_type    cmd,
   input  wire logic [IW-1:0]        scan_idx,
   input  wire lrra_pkg::mode_type   req_mode,
   input  wire lrra_pkg::field_type  req_offset,
   input  wire lrra_pkg::field_type  req_length,
   input  wire logic                 csr_we,
   input  wire lrra_pkg::field_type  csr_wdata,
   output logic                      rsp_valid,
   output lrra_pkg::status_type      rsp_status,
   output lrra_pkg::field_type       rsp_dest_offset,
   output logic                      rsp_move_needed,
   output lrra_pkg::field_type       rsp_move_source,
   output lrra_pkg::field_type       rsp_move_length,
   output lrra_pkg::field_type       rsp_read_offset,
   output lrra_pkg::field_type       rsp_valid_bytes
);
   import lrra_pkg::*;

   field_type  space_ff, ri_ff, vc_ff;
   field_type  space_in, ri_in, vc_in;
   logic       abort_ff, abort_in;
   logic [MAX_LOCKS-1:0] used_ff;
   field_type  lstart_ff [MAX_LOCKS];
   field_type  lend_ff   [MAX_LOCKS];

   mode_type   mode_ff;
   field_type  off_ff, len_ff;
   logic       wrap_ff;
   wide_type   lo1_ff, hi1_ff, hi2_ff;
   logic       ov1_ff, ov2_ff, fr_ok_ff, mt_ok_ff;
   logic [IW-1:0] fr_idx_ff, mt_idx_ff;

   wide_type   idx, lo1, e_start, e_end, fin_dest, reg_end;
   logic       wrap, e_used;

   status_type st;
   field_type  dest, ms, ml, ri_a, vc_a;
   logic       mv, lk_wr, lk_clr, any_lock, app_ok;

   assign idx  = wide_type'(ri_ff) + wide_type'(vc_ff);
   assign wrap = (idx > wide_type'(space_ff)) ||
                 ((wide_type'(space_ff) - idx) < wide_type'(req_length));
   assign lo1  = wrap ? '0 : idx;

   assign e_used  = used_ff[scan_idx];
   assign e_start = wide_type'(lstart_ff[scan_idx]);
   assign e_end   = wide_type'(lend_ff[scan_idx]);

   assign any_lock = |used_ff;
   assign fin_dest = (wrap_ff ? '0 : wide_type'(ri_ff)) + wide_type'(vc_ff);
   assign reg_end  = wide_type'(off_ff) + wide_type'(len_ff);

   always_comb begin
      st       = ST_OK;
      dest     = '0;
      mv       = 1'b0;
      ms       = '0;
      ml       = '0;
      ri_a     = ri_ff;
      vc_a     = vc_ff;
      abort_in = abort_ff;
      lk_wr    = 1'b0;
      lk_clr   = 1'b0;
      app_ok   = 1'b0;
      case (mode_ff) inside
         MODE_APPEND, MODE_APPEND_LOCK: begin
            if (mode_ff == MODE_APPEND_LOCK && !fr_ok_ff && !abort_ff) st = ST_TABLE_FULL;
            else if (abort_ff) st = ST_ABORTED;
            else if (len_ff > space_ff) st = ST_TOO_LARGE;
            else if (ov1_ff) st = ST_BLOCKED;
            else if (wrap_ff && ri_ff != '0 && vc_ff != '0 && ov2_ff) st = ST_BLOCKED;
            else if (fin_dest + wide_type'(len_ff) > wide_type'(space_ff)) st = ST_NO_ROOM;
            else app_ok = 1'b1;
            if (app_ok) begin
               if (wrap_ff && ri_ff != '0) begin
                  mv   = (vc_ff != '0);
                  ms   = mv ? ri_ff : '0;
                  ml   = mv ? vc_ff : '0;
                  ri_a = '0;
               end
               dest = field_type'(fin_dest);
               vc_a = vc_ff + len_ff;
               if (mode_ff == MODE_APPEND_LOCK && fr_ok_ff) begin
                  lk_wr = 1'b1;
                  if (dest == ri_a) begin
                     ri_a = ri_a + len_ff;
                     vc_a = vc_a - len_ff;
                  end
               end
            end
         end
         MODE_CONSUME: begin
            if (len_ff >= vc_ff && !any_lock) begin
               ri_a = '0;
               vc_a = '0;
            end else if (off_ff == ri_ff && len_ff <= vc_ff) begin
               ri_a = ri_ff + len_ff;
               vc_a = vc_ff - len_ff;
            end else st = ST_NOT_CONTIG;
         end
         MODE_LOCK, MODE_UNLOCK: begin
            if (off_ff > space_ff || len_ff > space_ff || reg_end > wide_type'(space_ff))
               st = ST_BAD_REGION;
            else if (mode_ff == MODE_LOCK) begin
               if (fr_ok_ff) lk_wr = 1'b1;
               else st = ST_TABLE_FULL;
            end else begin
               if (mt_ok_ff) lk_clr = 1'b1;
               else st = ST_NOT_FOUND;
            end
         end
         MODE_ABORT:       abort_in = 1'b1;
         MODE_CLEAR_ABORT: abort_in = 1'b0;
         default: ;
      endcase
   end

   always_comb begin
      space_in = space_ff;
      ri_in    = ri_ff;
      vc_in    = vc_ff;
      if (cmd.finish) begin
         ri_in = ri_a;
         vc_in = vc_a;
      end else if (csr_we && vc_ff == '0 && !any_lock) begin
         space_in = (csr_wdata > MAX_SPACE) ? MAX_SPACE : csr_wdata;
         ri_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         space_ff  <= MAX_SPACE;
         ri_ff     <= '0;
         vc_ff     <= '0;
         abort_ff  <= 1'b0;
         used_ff   <= '0;
         rsp_valid <= 1'b0;
      end else begin
         space_ff  <= space_in;
         ri_ff     <= ri_in;
         vc_ff     <= vc_in;
         rsp_valid <= cmd.finish;
         if (cmd.finish) begin
            abort_ff <= abort_in;
            if (lk_wr) used_ff[fr_idx_ff] <= 1'b1;
            if (lk_clr) used_ff[mt_idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && lk_wr) begin
         if (mode_ff == MODE_LOCK) begin
            lstart_ff[fr_idx_ff] <= off_ff;
            lend_ff[fr_idx_ff]   <= field_type'(reg_end);
         end else begin
            lstart_ff[fr_idx_ff] <= dest;
            lend_ff[fr_idx_ff]   <= dest + len_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         off_ff   <= req_offset;
         len_ff   <= req_length;
         wrap_ff  <= wrap;
         lo1_ff   <= lo1;
         hi1_ff   <= lo1 + wide_type'(req_length);
         hi2_ff   <= idx;
         ov1_ff   <= 1'b0;
         ov2_ff   <= 1'b0;
         fr_ok_ff <= 1'b0;
         mt_ok_ff <= 1'b0;
         fr_idx_ff <= '0;
         mt_idx_ff <= '0;
      end else if (cmd.scan) begin
         if (e_used) begin
            if (e_start < hi1_ff && e_end > lo1_ff) ov1_ff <= 1'b1;
            if (e_start < hi2_ff && e_end > wide_type'(ri_ff)) ov2_ff <= 1'b1;
            if (!mt_ok_ff && e_start == wide_type'(off_ff) && e_end == reg_end) begin
               mt_ok_ff  <= 1'b1;
               mt_idx_ff <= scan_idx;
            end
         end else if (!fr_ok_ff) begin
            fr_ok_ff  <= 1'b1;
            fr_idx_ff <= scan_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status      <= st;
         rsp_dest_offset <= dest;
         rsp_move_needed <= mv;
         rsp_move_source <= ms;
         rsp_move_length <= ml;
         rsp_read_offset <= ri_a;
         rsp_valid_bytes <= vc_a;
      end
   end
endmodule
`default_nettype wire

[rtl/core/locked_region_ring_allocator.sv]
// top level of the locked region ring allocator
`timescale 1ns / 1ps
`default_nettype none
// Offset bookkeeping for one contiguous byte buffer with a table of locked
// regions. A beat is taken when start is high and busy is low; busy then stays
// high through a scan of the lock table, one entry per cycle, and then the
// finish state. The result appears on the rsp_ ports for exactly one cycle
// with rsp_valid high, the first cycle in which busy is low again, and a new
// beat may be taken in that same cycle. The receiver cannot stall, so the
// result must be captured in that cycle. Write csr_wdata with csr_we only
// while idle; it takes effect only when the buffer is empty and no lock is
// held.
module locked_region_ring_allocator #(
   parameter int unsigned MAX_LOCKS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire lrra_pkg::mode_type   req_mode,
   input  wire lrra_pkg::field_type  req_offset,
   input  wire lrra_pkg::field_type  req_length,
   input  wire logic                 csr_we,
   input  wire lrra_pkg::field_type  csr_wdata,
   output logic                      rsp_valid,
   output lrra_pkg::status_type      rsp_status,
   output lrra_pkg::field_type       rsp_dest_offset,
   output logic                      rsp_move_needed,
   output lrra_pkg::field_type       rsp_move_source,
   output lrra_pkg::field_type       rsp_move_length,
   output lrra_pkg::field_type       rsp_read_offset,
   output lrra_pkg::field_type       rsp_valid_bytes
);
   import lrra_pkg::*;

   localparam int unsigned IW = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;

   cmd_type       cmd;
   logic [IW-1:0] scan_idx;

   lrra_ctrl #(.MAX_LOCKS(MAX_LOCKS), .IW(IW)) u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .cmd(cmd), .scan_idx(scan_idx)
   );

   lrra_dp #(.MAX_LOCKS(MAX_LOCKS), .IW(IW)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .scan_idx(scan_idx),
      .req_mode(req_mode), .req_offset(req_offset), .req_length(req_length),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_dest_offset(rsp_dest_offset), .rsp_move_needed(rsp_move_needed),
      .rsp_move_source(rsp_move_source), .rsp_move_length(rsp_move_length),
      .rsp_read_offset(rsp_read_offset), .rsp_valid_bytes(rsp_valid_bytes)
   );
endmodule
`default_nettype wire
